// ===== src/script_token_scanner_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the script token scanner
// Immediate-style concurrent property wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/sts_pkg.sv =====
// ---------------------------------------------------------------------------
// Script token scanner package
// Shared widths, codes, result record and keyword tables.
// ---------------------------------------------------------------------------
`default_nettype none
package sts_pkg;
   localparam int OffsetWidth = 24;
   localparam int LineWidth   = 20;
   localparam int ColumnWidth = 16;
   localparam int LengthWidth = 16;
   localparam int KwCount     = 20;

   localparam logic [2:0] ST_TOKEN = 3'd0;
   localparam logic [2:0] ST_END   = 3'd1;
   localparam logic [2:0] ST_CONT  = 3'd2;
   localparam logic [2:0] ST_KEY   = 3'd3;
   localparam logic [2:0] ST_STR   = 3'd4;
   localparam logic [2:0] ST_UNREC = 3'd5;

   localparam logic [5:0] K_NEWLINE = 6'd0;
   localparam logic [5:0] K_KEY     = 6'd1;
   localparam logic [5:0] K_NUMBER  = 6'd2;
   localparam logic [5:0] K_STRING  = 6'd3;
   localparam logic [5:0] K_QEQ     = 6'd4;
   localparam logic [5:0] K_PLUS    = 6'd6;
   localparam logic [5:0] K_MINUS   = 6'd8;
   localparam logic [5:0] K_STAR    = 6'd10;
   localparam logic [5:0] K_SLASH   = 6'd12;
   localparam logic [5:0] K_PERCENT = 6'd14;
   localparam logic [5:0] K_LPAREN  = 6'd15;
   localparam logic [5:0] K_RPAREN  = 6'd16;
   localparam logic [5:0] K_COMMA   = 6'd17;
   localparam logic [5:0] K_LBRACE  = 6'd18;
   localparam logic [5:0] K_RBRACE  = 6'd19;
   localparam logic [5:0] K_ASSIGN  = 6'd20;
   localparam logic [5:0] K_BANG    = 6'd22;
   localparam logic [5:0] K_SHL     = 6'd23;
   localparam logic [5:0] K_LE      = 6'd24;
   localparam logic [5:0] K_LT      = 6'd25;
   localparam logic [5:0] K_GE      = 6'd26;
   localparam logic [5:0] K_GT      = 6'd27;
   localparam logic [5:0] K_CARET   = 6'd28;
   localparam logic [5:0] K_AMP     = 6'd29;
   localparam logic [5:0] K_BAR     = 6'd30;
   localparam logic [5:0] K_KW0     = 6'd31;

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_CONT, M_KEY_FIRST, M_KEY, M_NUM, M_NUM_DOT,
      M_NUM_FRAC, M_STR, M_STR_ESC, M_OP, M_Q, M_WORD
   } mode_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [5:0]             kind;
      logic [OffsetWidth-1:0] offset;
      logic [LengthWidth-1:0] length;
      logic [LineWidth-1:0]   line;
      logic [ColumnWidth-1:0] column;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic       count2;
      result_type first;
      result_type second;
   } batch_type;

   function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
      logic [79:0] s;
      begin
         case (idx)
            5'd0:  s = {"log", 56'd0};
            5'd1:  s = {"routine", 24'd0};
            5'd2:  s = {"if", 64'd0};
            5'd3:  s = {"else", 48'd0};
            5'd4:  s = {"loop", 48'd0};
            5'd5:  s = {"Void", 48'd0};
            5'd6:  s = {"at", 64'd0};
            5'd7:  s = {"sizeof", 32'd0};
            5'd8:  s = {"typeof", 32'd0};
            5'd9:  s = {"through", 24'd0};
            5'd10: s = {"to", 64'd0};
            5'd11: s = {"blame", 40'd0};
            5'd12: s = {"catch", 40'd0};
            5'd13: s = {"with", 48'd0};
            5'd14: s = {"show", 48'd0};
            5'd15: s = {"getstring", 8'd0};
            5'd16: s = {"match", 40'd0};
            5'd17: s = {"skip", 48'd0};
            5'd18: s = {"break", 40'd0};
            5'd19: s = {"load", 48'd0};
            default: s = 80'd0;
         endcase
         if (pos > 4'd9)
            kw_char = 8'd0;
         else
            kw_char = s[79 - 8*pos -: 8];
      end
   endfunction

   function automatic logic [3:0] kw_len(input logic [4:0] idx);
      case (idx)
         5'd0: kw_len = 4'd3;   5'd1: kw_len = 4'd7;   5'd2: kw_len = 4'd2;
         5'd3: kw_len = 4'd4;   5'd4: kw_len = 4'd4;   5'd5: kw_len = 4'd4;
         5'd6: kw_len = 4'd2;   5'd7: kw_len = 4'd6;   5'd8: kw_len = 4'd6;
         5'd9: kw_len = 4'd7;   5'd10: kw_len = 4'd2;  5'd11: kw_len = 4'd5;
         5'd12: kw_len = 4'd5;  5'd13: kw_len = 4'd4;  5'd14: kw_len = 4'd4;
         5'd15: kw_len = 4'd9;  5'd16: kw_len = 4'd5;  5'd17: kw_len = 4'd4;
         5'd18: kw_len = 4'd5;  5'd19: kw_len = 4'd4;
         default: kw_len = 4'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

// ===== src/sts_front.sv =====
// ---------------------------------------------------------------------------
// Scanner front end
// Steps the scan state once per byte and forms up to two results.
// ---------------------------------------------------------------------------
`default_nettype none
module sts_front
   import sts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] text_byte,
   output batch_type       batch,
   output logic            batch_valid
);
   mode_type               mode_ff, mode_in;
   logic [OffsetWidth-1:0] off_ff, off_in, poff_ff, poff_in, hoff_ff, hoff_in, noff_ff, noff_in;
   logic [LineWidth-1:0]   line_ff, line_in, pline_ff, pline_in, hline_ff, hline_in;
   logic [LineWidth-1:0]   nline_ff, nline_in;
   logic [ColumnWidth-1:0] col_ff, col_in, pcol_ff, pcol_in, hcol_ff, hcol_in, ncol_ff, ncol_in;
   logic [LengthWidth-1:0] hlen_ff, hlen_in;
   logic [5:0]             hkind_ff, hkind_in;
   logic                   npend_ff, npend_in, nsent_ff, nsent_in, disc_ff, disc_in;
   logic [KwCount-1:0]     cand_ff, cand_in;
   logic [3:0]             wpos_ff, wpos_in;
   result_type             r0, r1;
   logic                   n0, n1, err;

   localparam logic [OffsetWidth-1:0] OffMax = '1;
   localparam logic [ColumnWidth-1:0] ColMax = '1;
   localparam logic [LineWidth-1:0]   LineMax = '1;
   localparam logic [LengthWidth-1:0] LenMax = '1;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      is_ident = is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [KwCount-1:0] kw_filter(input logic [KwCount-1:0] cand,
         input logic [3:0] pos, input logic [7:0] c);
      logic [KwCount-1:0] r;
      begin
         r = '0;
         for (int i = 0; i < KwCount; i++)
            if (cand[i] && pos < kw_len(5'(i)) && kw_char(5'(i), pos) == c)
               r[i] = 1'b1;
         kw_filter = r;
      end
   endfunction

   function automatic logic [LengthWidth-1:0] inc_len(input logic [LengthWidth-1:0] v);
      inc_len = (v == LenMax) ? v : v + 1'b1;
   endfunction

   function automatic result_type mk(input logic [2:0] st, input logic [5:0] k,
         input logic [OffsetWidth-1:0] o, input logic [LengthWidth-1:0] l,
         input logic [LineWidth-1:0] ln, input logic [ColumnWidth-1:0] cl);
      mk = '{status: st, kind: k, offset: o, length: l, line: ln, column: cl, last: 1'b0};
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       do_fresh, emitted;
      logic [5:0] k;
      logic [OffsetWidth-1:0] noff;
      logic [ColumnWidth-1:0] ncol;
      logic       kwhit;
      logic [5:0] kwk;
      result_type e;
      c = text_byte;
      mode_in = mode_ff; hkind_in = hkind_ff; hoff_in = hoff_ff; hline_in = hline_ff;
      hcol_in = hcol_ff; hlen_in = hlen_ff; npend_in = npend_ff; nsent_in = nsent_ff;
      noff_in = noff_ff; nline_in = nline_ff; ncol_in = ncol_ff; cand_in = cand_ff;
      wpos_in = wpos_ff; disc_in = disc_ff;
      off_in = off_ff; line_in = line_ff; col_in = col_ff;
      poff_in = poff_ff; pline_in = pline_ff; pcol_in = pcol_ff;
      r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0; err = 1'b0; do_fresh = 1'b0; emitted = 1'b0;
      k = '0; kwhit = 1'b0; kwk = '0; e = '0;
      noff = (off_ff == OffMax) ? off_ff : off_ff + 1'b1;
      ncol = (col_ff == ColMax) ? col_ff : col_ff + 1'b1;
      if (!disc_ff) begin
         case (mode_ff)
            M_COMMENT: if (c == 8'h0a || c == 8'h00) do_fresh = 1'b1;
            M_CONT:
               if (c == 8'h0a) mode_in = M_IDLE;
               else begin
                  e = mk(ST_CONT, K_NEWLINE, poff_ff, '0, pline_ff, pcol_ff); emitted = 1'b1;
               end
            M_KEY_FIRST:
               if (is_ident(c)) begin
                  hlen_in = LengthWidth'(1); mode_in = M_KEY;
               end else begin
                  e = mk(ST_KEY, K_NEWLINE, off_ff, '0, line_ff, col_ff); emitted = 1'b1;
               end
            M_KEY:
               if (is_ident(c)) hlen_in = inc_len(hlen_ff);
               else begin
                  e = mk(ST_TOKEN, hkind_ff, hoff_ff, hlen_ff, hline_ff, hcol_ff);
                  emitted = 1'b1; do_fresh = 1'b1;
               end
            M_NUM, M_NUM_FRAC:
               if (is_digit(c)) hlen_in = inc_len(hlen_ff);
               else if (c == "." && mode_ff == M_NUM) mode_in = M_NUM_DOT;
               else begin
                  e = mk(ST_TOKEN, hkind_ff, hoff_ff, hlen_ff, hline_ff, hcol_ff);
                  emitted = 1'b1; do_fresh = 1'b1;
               end
            M_NUM_DOT:
               if (is_digit(c)) begin
                  hlen_in = inc_len(inc_len(hlen_ff)); mode_in = M_NUM_FRAC;
               end else begin
                  r0 = mk(ST_TOKEN, hkind_ff, hoff_ff, hlen_ff, hline_ff, hcol_ff); n0 = 1'b1;
                  r1 = mk(ST_UNREC, K_NEWLINE, poff_ff, '0, pline_ff, pcol_ff); n1 = 1'b1;
               end
            M_STR, M_STR_ESC:
               if (mode_ff == M_STR_ESC && (c == 8'h5c || c == 8'h22)) begin
                  hlen_in = inc_len(hlen_ff); mode_in = M_STR;
               end else if (c == 8'h22) begin
                  e = mk(ST_TOKEN, hkind_ff, hoff_ff, hlen_ff, hline_ff, hcol_ff);
                  emitted = 1'b1; mode_in = M_IDLE;
               end else if (c == 8'h0a || c == 8'h00) begin
                  e = mk(ST_STR, K_NEWLINE, off_ff, '0, line_ff, col_ff); emitted = 1'b1;
               end else begin
                  hlen_in = inc_len(hlen_ff);
                  mode_in = (c == 8'h5c) ? M_STR_ESC : M_STR;
               end
            M_OP:
               if (hkind_ff == K_PERCENT && c == "%") mode_in = M_COMMENT;
               else begin
                  if (hkind_ff == K_PERCENT) nsent_in = 1'b0;
                  if (c == "=") begin
                     k = (hkind_ff == K_LT) ? K_LE : (hkind_ff == K_GT) ? K_GE : hkind_ff - 1'b1;
                     e = mk(ST_TOKEN, k, hoff_ff, LengthWidth'(2), hline_ff, hcol_ff);
                     emitted = 1'b1; mode_in = M_IDLE;
                  end else if (hkind_ff == K_LT && c == "<") begin
                     e = mk(ST_TOKEN, K_SHL, hoff_ff, LengthWidth'(2), hline_ff, hcol_ff);
                     emitted = 1'b1; mode_in = M_IDLE;
                  end else begin
                     e = mk(ST_TOKEN, hkind_ff, hoff_ff, hlen_ff, hline_ff, hcol_ff);
                     emitted = 1'b1; do_fresh = 1'b1;
                  end
               end
            M_Q:
               if (c == "=") begin
                  e = mk(ST_TOKEN, K_QEQ, hoff_ff, LengthWidth'(2), hline_ff, hcol_ff);
                  emitted = 1'b1; mode_in = M_IDLE;
               end else begin
                  e = mk(ST_UNREC, K_NEWLINE, hoff_ff, '0, hline_ff, hcol_ff); emitted = 1'b1;
               end
            M_WORD:
               if (is_ident(c)) begin
                  cand_in = kw_filter(cand_ff, wpos_ff, c);
                  if (wpos_ff < 4'd15) wpos_in = wpos_ff + 1'b1;
                  if (cand_in == '0) begin
                     e = mk(ST_UNREC, K_NEWLINE, hoff_ff, '0, hline_ff, hcol_ff); emitted = 1'b1;
                  end
               end else begin
                  for (int i = KwCount - 1; i >= 0; i--)
                     if (cand_ff[i] && kw_len(5'(i)) == wpos_ff) begin
                        kwhit = 1'b1; kwk = K_KW0 + 6'(i);
                     end
                  if (kwhit) begin
                     e = mk(ST_TOKEN, kwk, hoff_ff, LengthWidth'(wpos_ff), hline_ff, hcol_ff);
                     emitted = 1'b1; cand_in = '0; wpos_in = '0; do_fresh = 1'b1;
                  end else begin
                     e = mk(ST_UNREC, K_NEWLINE, hoff_ff, '0, hline_ff, hcol_ff); emitted = 1'b1;
                  end
               end
            default: do_fresh = 1'b1;
         endcase
         if (emitted) begin
            r0 = e; n0 = 1'b1;
         end
         if (do_fresh) begin
            mode_in = M_IDLE;
            e = '0;
            emitted = 1'b0;
            if (c == " " || c == 8'h09) begin
            end else if (c == 8'h0a) begin
               if (!npend_ff && !nsent_in) begin
                  npend_in = 1'b1; noff_in = off_ff; nline_in = line_ff; ncol_in = col_ff;
               end
            end else if (c == 8'h00) begin
               e = mk(ST_END, K_NEWLINE, off_ff, '0, line_ff, col_ff); emitted = 1'b1;
            end else if (c == 8'h5c) begin
               mode_in = M_CONT;
            end else begin
               if (npend_ff) begin
                  e = mk(ST_TOKEN, K_NEWLINE, noff_ff, LengthWidth'(1), nline_ff, ncol_ff);
                  emitted = 1'b1;
               end
               if (c == "%") begin
                  if (npend_ff) nsent_in = 1'b1;
                  npend_in = 1'b0;
                  hkind_in = K_PERCENT; hoff_in = off_ff; hline_in = line_ff;
                  hcol_in = col_ff; hlen_in = LengthWidth'(1); mode_in = M_OP;
               end else begin
                  npend_in = 1'b0; nsent_in = 1'b0;
                  case (c)
                     "(": k = K_LPAREN;  ")": k = K_RPAREN; ",": k = K_COMMA;
                     "{": k = K_LBRACE;  "}": k = K_RBRACE; "=": k = K_ASSIGN;
                     "^": k = K_CARET;   "&": k = K_AMP;    "|": k = K_BAR;
                     "+": k = K_PLUS;    "-": k = K_MINUS;  "*": k = K_STAR;
                     "/": k = K_SLASH;   "!": k = K_BANG;   "<": k = K_LT;
                     ">": k = K_GT;
                     default: k = '0;
                  endcase
                  if (k != '0 && (k >= K_LPAREN && k != K_BANG && k != K_LT && k != K_GT)) begin
                     if (emitted) begin
                        r1 = mk(ST_TOKEN, k, off_ff, LengthWidth'(1), line_ff, col_ff); n1 = 1'b1;
                     end else begin
                        e = mk(ST_TOKEN, k, off_ff, LengthWidth'(1), line_ff, col_ff);
                        emitted = 1'b1;
                     end
                  end else if (k != '0) begin
                     hkind_in = k; hoff_in = off_ff; hline_in = line_ff; hcol_in = col_ff;
                     hlen_in = LengthWidth'(1); mode_in = M_OP;
                  end else if (c == "?") begin
                     hkind_in = K_QEQ; hoff_in = off_ff; hline_in = line_ff; hcol_in = col_ff;
                     hlen_in = LengthWidth'(1); mode_in = M_Q;
                  end else if (c == ":" || c == 8'h22) begin
                     hkind_in = (c == ":") ? K_KEY : K_STRING; hoff_in = noff;
                     hline_in = line_ff; hcol_in = ncol; hlen_in = '0;
                     mode_in = (c == ":") ? M_KEY_FIRST : M_STR;
                  end else if (is_digit(c)) begin
                     hkind_in = K_NUMBER; hoff_in = off_ff; hline_in = line_ff; hcol_in = col_ff;
                     hlen_in = LengthWidth'(1); mode_in = M_NUM;
                  end else begin
                     cand_in = kw_filter('1, 4'd0, c);
                     if (cand_in == '0) begin
                        if (emitted) begin
                           r1 = mk(ST_UNREC, K_NEWLINE, off_ff, '0, line_ff, col_ff); n1 = 1'b1;
                        end else begin
                           e = mk(ST_UNREC, K_NEWLINE, off_ff, '0, line_ff, col_ff);
                           emitted = 1'b1;
                        end
                     end else begin
                        hkind_in = K_NEWLINE; hoff_in = off_ff; hline_in = line_ff;
                        hcol_in = col_ff; hlen_in = '0; wpos_in = 4'd1; mode_in = M_WORD;
                     end
                  end
               end
            end
            if (emitted) begin
               if (n0) begin
                  r1 = e; n1 = 1'b1;
               end else begin
                  r0 = e; n0 = 1'b1;
               end
            end else if (n1 && !n0) begin
               r0 = r1; n0 = 1'b1; n1 = 1'b0;
            end
         end
         err = (n0 && r0.status != ST_TOKEN) || (n1 && r1.status != ST_TOKEN);
         if (err) begin
            disc_in = (c != 8'h00);
         end else begin
            poff_in = off_ff; pline_in = line_ff; pcol_in = col_ff; off_in = noff;
            if (c == 8'h0a) begin
               line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
               col_in = ColumnWidth'(1);
            end else col_in = ncol;
         end
      end
      if (n1) r1.last = 1'b1;
      else r0.last = 1'b1;
   end

   logic restart;
   assign restart = reset || (take && ((disc_ff && text_byte == 8'h00) || (!disc_ff && err &&
                    text_byte == 8'h00)));

   always_ff @(posedge clock) begin
      if (restart) begin
         mode_ff <= M_IDLE; off_ff <= '0; line_ff <= LineWidth'(1); col_ff <= ColumnWidth'(1);
         hkind_ff <= '0; hoff_ff <= '0; hline_ff <= LineWidth'(1); hcol_ff <= ColumnWidth'(1);
         hlen_ff <= '0; npend_ff <= 1'b0; noff_ff <= '0; nline_ff <= LineWidth'(1);
         ncol_ff <= ColumnWidth'(1); cand_ff <= '0; wpos_ff <= '0; disc_ff <= 1'b0;
         poff_ff <= '0; pline_ff <= LineWidth'(1); pcol_ff <= ColumnWidth'(1); nsent_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in; off_ff <= off_in; line_ff <= line_in; col_ff <= col_in;
         hkind_ff <= hkind_in; hoff_ff <= hoff_in; hline_ff <= hline_in; hcol_ff <= hcol_in;
         hlen_ff <= hlen_in; npend_ff <= npend_in; noff_ff <= noff_in; nline_ff <= nline_in;
         ncol_ff <= ncol_in; cand_ff <= cand_in; wpos_ff <= wpos_in; disc_ff <= disc_in;
         poff_ff <= poff_in; pline_ff <= pline_in; pcol_ff <= pcol_in; nsent_ff <= nsent_in;
      end
   end

   assign batch       = '{count2: n1, first: r0, second: r1};
   assign batch_valid = take && n0;
endmodule
`default_nettype wire

// ===== src/sts_back.sv =====
// ---------------------------------------------------------------------------
// Scanner back end
// Queues result batches and hands results out one transfer at a time.
// ---------------------------------------------------------------------------
`default_nettype none
module sts_back
   import sts_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  batch_type  batch,
   input  wire logic  batch_valid,
   output logic       room,
   output logic       out_valid,
   output result_type out_result,
   input  wire logic  out_stall
);
   `include "script_token_scanner_macros.svh"

   batch_type  q_ff [2];
   batch_type  q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in, sub_ff, sub_in;
   logic       pop, popb;

   assign out_valid  = (cnt_ff != 2'd0);
   assign out_result = sub_ff ? q_ff[rd_ff].second : q_ff[rd_ff].first;
   assign pop        = out_valid && !out_stall;
   assign popb       = pop && (sub_ff || !q_ff[rd_ff].count2);
   assign room       = (cnt_ff != 2'd2) || popb;

   always_comb begin
      q_in = q_ff;
      wr_in = wr_ff; rd_in = rd_ff; sub_in = sub_ff;
      if (batch_valid) begin
         q_in[wr_ff] = batch; wr_in = !wr_ff;
      end
      if (pop) begin
         if (popb) begin
            rd_in = !rd_ff; sub_in = 1'b0;
         end else sub_in = 1'b1;
      end
      cnt_in = cnt_ff + 2'(batch_valid) - 2'(popb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; wr_ff <= 1'b0; rd_ff <= 1'b0; sub_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; wr_ff <= wr_in; rd_ff <= rd_in; sub_ff <= sub_in;
      end
      q_ff <= q_in;
   end

   `STS_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `STS_ASSERT_IMPL(a_no_overflow, clock, reset, cnt_ff == 2'd2 && !popb, !batch_valid)
   `STS_ASSERT_IMPL(a_sub_valid, clock, reset, sub_ff, out_valid)
   `STS_ASSERT_NEXT(a_hold_sub, clock, reset, out_valid && out_stall && sub_ff, sub_ff)
endmodule
`default_nettype wire

// ===== src/script_token_scanner.sv =====
// ---------------------------------------------------------------------------
// Script token scanner
// Streaming tokenizer: one source byte per transfer in, tokens and status out.
// ---------------------------------------------------------------------------
// Input channel req_: one byte per transfer, zero ends the text.
// Result channel rsp_: status, token kind, offset, length, line, column and a
// last_result flag marking the final result caused by a byte.
// A byte yields zero, one or two results; they are registered into the queue and
// appear on rsp_ after earlier results have left. One byte per cycle is accepted
// while the queue has room; a byte giving two results is handed out as two transfers.
// A two-entry queue of result batches sits between the scan state and the
// output, so the scanner keeps taking bytes while results wait.
// When rsp_stall holds, the queue fills and req_stall rises.
// Reset (synchronous) empties the queue and returns the scanner to the start
// of a text: offset 0, line 1, column 1, no pending token.
// ---------------------------------------------------------------------------
`default_nettype none
module script_token_scanner
   import sts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_text_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [5:0]                  rsp_token_kind,
   output logic [OffsetWidth-1:0]      rsp_start_offset,
   output logic [LengthWidth-1:0]      rsp_token_length,
   output logic [LineWidth-1:0]        rsp_start_line,
   output logic [ColumnWidth-1:0]      rsp_start_column,
   output logic                        rsp_last_result
);
   batch_type  batch;
   logic       batch_valid, room, take;
   result_type res;

   assign req_stall = !room;
   assign take      = req_valid && room;

   sts_front u_front (
      .clock(clock), .reset(reset), .take(take), .text_byte(req_text_byte),
      .batch(batch), .batch_valid(batch_valid)
   );

   sts_back u_back (
      .clock(clock), .reset(reset), .batch(batch), .batch_valid(batch_valid),
      .room(room), .out_valid(rsp_valid), .out_result(res), .out_stall(rsp_stall)
   );

   assign rsp_status       = res.status;
   assign rsp_token_kind   = res.kind;
   assign rsp_start_offset = res.offset;
   assign rsp_token_length = res.length;
   assign rsp_start_line   = res.line;
   assign rsp_start_column = res.column;
   assign rsp_last_result  = res.last;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// Script token scanner testbench
// Feeds texts one byte per transfer. Directed texts come first, then random
// texts built from tokens, comments, continuations and noise. A scoreboard
// predicts every result and compares each one field by field. Both channels
// idle at random, with one long output hold and one drain pause.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import sts_pkg::*;

class token_scoreboard;
   string kw_words[20] = '{"log", "routine", "if", "else", "loop", "Void", "at",
      "sizeof", "typeof", "through", "to", "blame", "catch", "with", "show",
      "getstring", "match", "skip", "break", "load"};

   mode_type               mode;
   logic [OffsetWidth-1:0] off, hoff, nloff, poff;
   logic [LineWidth-1:0]   line, hline, nlline, pline;
   logic [ColumnWidth-1:0] col, hcol, nlcol, pcol;
   logic [LengthWidth-1:0] hlen;
   logic [5:0]             hkind;
   logic [19:0]            cand;
   logic [3:0]             wpos;
   bit                     nlp, disc, nlsent, err, endf;
   result_type             res[2];
   int                     nres;
   result_type             expected_q[$];
   int                     errors, tokens, faults, texts;

   function new();
      restart();
   endfunction

   function void restart();
      mode = M_IDLE; off = 0; line = 1; col = 1;
      hkind = 0; hoff = 0; hline = 1; hcol = 1; hlen = 0;
      nlp = 0; nloff = 0; nlline = 1; nlcol = 1;
      cand = 0; wpos = 0; disc = 0; poff = 0; pline = 1; pcol = 1; nlsent = 0;
   endfunction

   function logic [OffsetWidth-1:0] inc_off(logic [OffsetWidth-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function logic [ColumnWidth-1:0] inc_col(logic [ColumnWidth-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function logic [LengthWidth-1:0] inc_len(logic [LengthWidth-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit is_ident(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function void emit(logic [2:0] st, logic [5:0] k, logic [OffsetWidth-1:0] o,
                      logic [LengthWidth-1:0] l, logic [LineWidth-1:0] ln,
                      logic [ColumnWidth-1:0] c);
      if (nres >= 2) return;
      res[nres] = '{status: st, kind: k, offset: o, length: l, line: ln, column: c,
                    last: 1'b0};
      nres++;
      if (st == ST_END) endf = 1;
      if (st >= ST_CONT) err = 1;
   endfunction

   function void hold_here(logic [5:0] k, logic [LengthWidth-1:0] l);
      hkind = k; hoff = off; hline = line; hcol = col; hlen = l;
   endfunction

   function void hold_next(logic [5:0] k);
      hkind = k; hoff = inc_off(off); hline = line; hcol = inc_col(col); hlen = 0;
   endfunction

   function logic [19:0] kw_match(logic [19:0] cs, int pos, logic [7:0] c);
      logic [19:0] r;
      r = 0;
      for (int i = 0; i < 20; i++)
         if (cs[i] && pos < kw_words[i].len() && kw_words[i][pos] == c) r[i] = 1;
      return r;
   endfunction

   function void fresh(logic [7:0] c);
      logic [5:0] k;
      k = 0;
      mode = M_IDLE;
      if (c == " " || c == 8'h09) return;
      if (c == 8'h0a) begin
         if (!nlp && !nlsent) begin
            nlp = 1; nloff = off; nlline = line; nlcol = col;
         end
         return;
      end
      if (c == 0) begin
         emit(ST_END, 0, off, 0, line, col);
         return;
      end
      if (c == "\\") begin
         mode = M_CONT;
         return;
      end
      if (nlp) emit(ST_TOKEN, K_NEWLINE, nloff, 1, nlline, nlcol);
      if (c == "%") begin
         if (nlp) nlsent = 1;
         nlp = 0;
         hold_here(K_PERCENT, 1);
         mode = M_OP;
         return;
      end
      nlp = 0;
      nlsent = 0;
      case (c)
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         ",": k = K_COMMA;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "=": k = K_ASSIGN;
         "^": k = K_CARET;
         "&": k = K_AMP;
         "|": k = K_BAR;
         default: k = 0;
      endcase
      if (k != 0) begin
         emit(ST_TOKEN, k, off, 1, line, col);
         return;
      end
      case (c)
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "!": k = K_BANG;
         "<": k = K_LT;
         ">": k = K_GT;
         default: k = 0;
      endcase
      if (k != 0) begin
         hold_here(k, 1);
         mode = M_OP;
      end else if (c == "?") begin
         hold_here(K_QEQ, 1);
         mode = M_Q;
      end else if (c == ":") begin
         hold_next(K_KEY);
         mode = M_KEY_FIRST;
      end else if (c == "\"") begin
         hold_next(K_STRING);
         mode = M_STR;
      end else if (is_digit(c)) begin
         hold_here(K_NUMBER, 1);
         mode = M_NUM;
      end else begin
         cand = kw_match(20'hFFFFF, 0, c);
         if (cand == 0) begin
            emit(ST_UNREC, 0, off, 0, line, col);
            return;
         end
         hold_here(0, 0);
         wpos = 1;
         mode = M_WORD;
      end
   endfunction

   function void str_byte(logic [7:0] c);
      mode = M_STR;
      if (c == "\"") begin
         emit(ST_TOKEN, hkind, hoff, hlen, hline, hcol);
         mode = M_IDLE;
      end else if (c == 8'h0a || c == 0) begin
         emit(ST_STR, 0, off, 0, line, col);
      end else begin
         hlen = inc_len(hlen);
         if (c == "\\") mode = M_STR_ESC;
      end
   endfunction

   function void op_byte(logic [7:0] c);
      logic [5:0] k;
      k = hkind;
      if (k == K_PERCENT) begin
         if (c == "%") begin
            mode = M_COMMENT;
            return;
         end
         nlsent = 0;
      end
      if (c == "=") begin
         k = (k == K_LT) ? K_LE : (k == K_GT) ? K_GE : k - 1'b1;
         emit(ST_TOKEN, k, hoff, 2, hline, hcol);
         mode = M_IDLE;
      end else if (k == K_LT && c == "<") begin
         emit(ST_TOKEN, K_SHL, hoff, 2, hline, hcol);
         mode = M_IDLE;
      end else begin
         emit(ST_TOKEN, hkind, hoff, hlen, hline, hcol);
         fresh(c);
      end
   endfunction

   function void word_byte(logic [7:0] c);
      if (is_ident(c)) begin
         cand = kw_match(cand, wpos, c);
         if (wpos < 15) wpos++;
         if (cand == 0) emit(ST_UNREC, 0, hoff, 0, hline, hcol);
         return;
      end
      for (int i = 0; i < 20; i++)
         if (cand[i] && kw_words[i].len() == wpos) begin
            emit(ST_TOKEN, K_KW0 + 6'(i), hoff, LengthWidth'(wpos), hline, hcol);
            cand = 0;
            wpos = 0;
            fresh(c);
            return;
         end
      emit(ST_UNREC, 0, hoff, 0, hline, hcol);
   endfunction

   function void note_byte(logic [7:0] c);
      nres = 0; err = 0; endf = 0;
      if (c == 0) texts++;
      if (disc) begin
         if (c == 0) restart();
         return;
      end
      case (mode)
         M_COMMENT: if (c == 8'h0a || c == 0) fresh(c);
         M_CONT: if (c == 8'h0a) mode = M_IDLE; else emit(ST_CONT, 0, poff, 0, pline, pcol);
         M_KEY_FIRST:
            if (is_ident(c)) begin
               hlen = 1;
               mode = M_KEY;
            end else emit(ST_KEY, 0, off, 0, line, col);
         M_KEY:
            if (is_ident(c)) hlen = inc_len(hlen);
            else begin
               emit(ST_TOKEN, hkind, hoff, hlen, hline, hcol);
               fresh(c);
            end
         M_NUM, M_NUM_FRAC:
            if (is_digit(c)) hlen = inc_len(hlen);
            else if (c == "." && mode == M_NUM) mode = M_NUM_DOT;
            else begin
               emit(ST_TOKEN, hkind, hoff, hlen, hline, hcol);
               fresh(c);
            end
         M_NUM_DOT:
            if (is_digit(c)) begin
               hlen = inc_len(inc_len(hlen));
               mode = M_NUM_FRAC;
            end else begin
               emit(ST_TOKEN, hkind, hoff, hlen, hline, hcol);
               emit(ST_UNREC, 0, poff, 0, pline, pcol);
            end
         M_STR: str_byte(c);
         M_STR_ESC:
            if (c == "\\" || c == "\"") begin
               hlen = inc_len(hlen);
               mode = M_STR;
            end else str_byte(c);
         M_OP: op_byte(c);
         M_Q:
            if (c == "=") begin
               emit(ST_TOKEN, K_QEQ, hoff, 2, hline, hcol);
               mode = M_IDLE;
            end else emit(ST_UNREC, 0, hoff, 0, hline, hcol);
         M_WORD: word_byte(c);
         default: fresh(c);
      endcase
      if (err || endf) begin
         if (c == 0) restart();
         else disc = 1;
      end else begin
         poff = off; pline = line; pcol = col;
         off = inc_off(off);
         if (c == 8'h0a) begin
            line = (&line) ? line : line + 1'b1;
            col = 1;
         end else col = inc_col(col);
      end
      if (nres > 0) res[nres-1].last = 1;
      for (int i = 0; i < nres; i++) begin
         expected_q.push_back(res[i]);
         if (res[i].status == ST_TOKEN) tokens++;
         if (res[i].status >= ST_CONT) faults++;
      end
   endfunction

   function void check_result(result_type got);
      result_type w;
      if (expected_q.size() == 0) begin
         $error("unexpected result: status %0d kind %0d", got.status, got.kind);
         errors++;
         return;
      end
      w = expected_q.pop_front();
      if (got.status !== w.status) begin
         $error("status: expected %0d, actual %0d", w.status, got.status); errors++;
      end
      if (got.kind !== w.kind) begin
         $error("token_kind: expected %0d, actual %0d", w.kind, got.kind); errors++;
      end
      if (got.offset !== w.offset) begin
         $error("start_offset: expected %0d, actual %0d", w.offset, got.offset); errors++;
      end
      if (got.length !== w.length) begin
         $error("token_length: expected %0d, actual %0d", w.length, got.length); errors++;
      end
      if (got.line !== w.line) begin
         $error("start_line: expected %0d, actual %0d", w.line, got.line); errors++;
      end
      if (got.column !== w.column) begin
         $error("start_column: expected %0d, actual %0d", w.column, got.column); errors++;
      end
      if (got.last !== w.last) begin
         $error("last_result: expected %0d, actual %0d", w.last, got.last); errors++;
      end
   endfunction
endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   logic [7:0]             req_text_byte = 0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   logic [2:0]             rsp_status;
   logic [5:0]             rsp_token_kind;
   logic [OffsetWidth-1:0] rsp_start_offset;
   logic [LengthWidth-1:0] rsp_token_length;
   logic [LineWidth-1:0]   rsp_start_line;
   logic [ColumnWidth-1:0] rsp_start_column;
   logic                   rsp_last_result;

   token_scoreboard sb = new();
   int  cycle = 0;
   int  sent = 0;
   bit  hold_done = 0;
   int  hold_count = 0;
   logic [7:0] text_q[$];

   script_token_scanner u_dut (.*);

   always #4 clock = ~clock;

   // quiet stretch with no idling on either side
   function bit quiet();
      return sent > 100 && sent < 200;
   endfunction

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 300000) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_text_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result('{status: rsp_status, kind: rsp_token_kind,
               offset: rsp_start_offset, length: rsp_token_length, line: rsp_start_line,
               column: rsp_start_column, last: rsp_last_result});
      end
   end

   // hold the output once for a long stretch, otherwise stall at random
   always @(negedge clock) begin
      if (!hold_done && sent > 350) begin
         rsp_stall <= 1;
         hold_count <= hold_count + 1;
         if (hold_count == 80) hold_done <= 1;
      end else
         rsp_stall <= !quiet() && $urandom_range(99) < 36;
   end

   task automatic send_byte(logic [7:0] b);
      while (!quiet() && $urandom_range(99) < 36) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic build_text();
      int n;
      string ops;
      string tails;
      ops = "+-*/%!<>?=()!,{}^&|";
      tails = "=<%";
      n = $urandom_range(3, 12);
      repeat (n) begin
         case ($urandom_range(13))
            0, 1: add_str(sb.kw_words[$urandom_range(19)]);
            2: repeat ($urandom_range(1, 4)) text_q.push_back(8'("a" + $urandom_range(25)));
            3: begin
               add_str($sformatf("%0d", $urandom_range(9999)));
               if ($urandom_range(2) == 0) add_str($sformatf(".%0d", $urandom_range(99)));
               else if ($urandom_range(9) == 0) add_str(".");
            end
            4: begin
               text_q.push_back("\"");
               repeat ($urandom_range(0, 5))
                  case ($urandom_range(4))
                     0: add_str("\\\"");
                     1: add_str("\\\\");
                     2: add_str("\\n");
                     default: text_q.push_back(8'($urandom_range(32, 126)));
                  endcase
               if ($urandom_range(7) != 0) text_q.push_back("\"");
            end
            5: begin
               text_q.push_back(":");
               repeat ($urandom_range(0, 4)) text_q.push_back(8'("A" + $urandom_range(25)));
               if ($urandom_range(1)) text_q.push_back("_");
            end
            6, 7: begin
               text_q.push_back(ops[$urandom_range(18)]);
               if ($urandom_range(1)) text_q.push_back(tails[$urandom_range(2)]);
            end
            8: repeat ($urandom_range(1, 3)) text_q.push_back(8'h0a);
            9: add_str("%% note\n");
            10: add_str($urandom_range(5) ? "\\\n" : "\\x");
            11: text_q.push_back(8'($urandom_range(1, 255)));
            default: text_q.push_back($urandom_range(1) ? " " : 8'h09);
         endcase
         if ($urandom_range(2) != 0) text_q.push_back(" ");
      end
      if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(255)));
      text_q.push_back(0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      add_str("?=<<%=:k\"\\\"\\\\\"1.5\n\nVoid %% c");
      text_q.push_back(0);
      text_q.push_back(8'hff);
      add_str(" 7");
      text_q.push_back(0);
      while (sent < 500) begin
         if (text_q.size() == 0) build_text();
         send_byte(text_q.pop_front());
         sent++;
         if (sent == 250) begin
            @(negedge clock);
            req_valid <= 0;
            wait (sb.expected_q.size() == 0);
         end
      end
      while (text_q.size() != 0) send_byte(text_q.pop_front());
      @(negedge clock);
      req_valid <= 0;
      wait (sb.expected_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("Scanned %0d texts: %0d tokens and %0d error reports predicted.",
               sb.texts, sb.tokens, sb.faults);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
